FILE: sv/pogs_pkg.sv
// Package for the predicted obstacle grid stamp: item, result, config and command types,
// operation and register codes, occupancy and mark-count constants.
// No dependencies.
`default_nettype none
package pogs_pkg;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_STAMP   = 2'd1,
      OP_READ    = 2'd2,
      OP_REFRESH = 2'd3
   } op_type;

   // Configuration register indexes
   localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
   localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
   localparam logic [2:0] REG_ORIGIN_X    = 3'd2;
   localparam logic [2:0] REG_ORIGIN_Y    = 3'd3;
   localparam logic [2:0] REG_CELLS_PER_M = 3'd4;
   localparam logic [2:0] REG_STEP_DIST   = 3'd5;
   localparam logic [2:0] REG_LAYERS      = 3'd6;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [7:0]  OCCUPIED = 8'd100;
   localparam logic [10:0] MARK_MAX = 11'd2047;

   typedef struct packed {
      op_type             op;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [15:0] heading_cos;
      logic signed [15:0] heading_sin;
      logic [13:0]        cell_index;
      logic [3:0]         layer_select;
      logic signed [7:0]  cell_value;
   } req_type;

   typedef struct packed {
      logic signed [7:0] read_value;
      logic [10:0]       cells_marked;
   } rsp_type;

   typedef struct packed {
      logic [7:0]         grid_width;
      logic [7:0]         grid_height;
      logic signed [23:0] origin_x;
      logic signed [23:0] origin_y;
      logic [15:0]        cells_per_meter;
      logic signed [16:0] step_distance;
      logic [4:0]         layers_in_use;
   } cfg_type;

   // Effective grid geometry after clamping
   typedef struct packed {
      logic [7:0] width;
      logic [7:0] height;
      logic [4:0] layers;
   } geo_type;

   // Classified item handed from front to back
   typedef struct packed {
      req_type req;
      logic    idx_ok;
      logic    layer_ok;
   } cmd_type;

endpackage
`default_nettype wire

FILE: sv/predicted_obstacle_grid_stamp.sv
// Predicted obstacle grid stamp, top level: configuration registers, grid clamping,
// front end, back end and result queue. Uses pogs_pkg, pogs_front, pogs_back, pogs_fifo.
//
// Usage: items enter on req_push/req_full, results leave on rsp_empty/rsp_pop, one
// result per item in order. Config is written on csr_write/csr_index/csr_data while idle.
// Items are queued (four deep) ahead of a sequencer that runs one item at a time:
//   load     base grid write as the item is taken
//   read     registered layer memory read
//   refresh  every base memory cell copied into each layer in use, one cell copy a cycle
//   stamp    heading products first; the per-layer part is ten steps of the
//            shared 25x17 multiplier and rounding, one clip step, one cell write a cycle
// The layer memory has a single write port, shared by refresh and stamp.
// Results wait in a two-entry queue; while it is full the sequencer holds the next item,
// and the input keeps accepting until the command queue fills.
// Reset restores the register defaults and empties both queues; grid contents stay
// undefined until written.
`default_nettype none
module predicted_obstacle_grid_stamp #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128,
   parameter int MAX_LAYERS = 16,
   parameter int BOX_RADIUS = 5
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_push,
   input  wire pogs_pkg::req_type                 req_data,
   output logic                                   req_full,
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output pogs_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_write,
   input  wire logic [pogs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [pogs_pkg::CSR_DATA_W-1:0]   csr_data
);
   localparam int RSP_W = $bits(pogs_pkg::rsp_type);

   pogs_pkg::cfg_type cfg_ff;
   pogs_pkg::geo_type geo;
   pogs_pkg::cmd_type cmd;
   pogs_pkg::rsp_type out_data;
   logic              cmd_empty, cmd_pop, out_push, out_full;
   logic [RSP_W-1:0]  rsp_bits;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width      <= 8'd128;
         cfg_ff.grid_height     <= 8'd128;
         cfg_ff.origin_x        <= '0;
         cfg_ff.origin_y        <= '0;
         cfg_ff.cells_per_meter <= 16'd2560;
         cfg_ff.step_distance   <= '0;
         cfg_ff.layers_in_use   <= 5'd10;
      end else if (csr_write) begin
         case (csr_index)
            pogs_pkg::REG_GRID_WIDTH:  cfg_ff.grid_width      <= csr_data[7:0];
            pogs_pkg::REG_GRID_HEIGHT: cfg_ff.grid_height     <= csr_data[7:0];
            pogs_pkg::REG_ORIGIN_X:    cfg_ff.origin_x        <= csr_data[23:0];
            pogs_pkg::REG_ORIGIN_Y:    cfg_ff.origin_y        <= csr_data[23:0];
            pogs_pkg::REG_CELLS_PER_M: cfg_ff.cells_per_meter <= csr_data[15:0];
            pogs_pkg::REG_STEP_DIST:   cfg_ff.step_distance   <= csr_data[16:0];
            pogs_pkg::REG_LAYERS:      cfg_ff.layers_in_use   <= csr_data[4:0];
            default: begin
            end
         endcase
      end
   end

   // Clamp geometry to the built maximums
   always_comb begin
      if (cfg_ff.grid_width == '0) begin
         geo.width = 8'd1;
      end else if (32'(cfg_ff.grid_width) > MAX_WIDTH) begin
         geo.width = 8'(MAX_WIDTH);
      end else begin
         geo.width = cfg_ff.grid_width;
      end
      if (cfg_ff.grid_height == '0) begin
         geo.height = 8'd1;
      end else if (32'(cfg_ff.grid_height) > MAX_HEIGHT) begin
         geo.height = 8'(MAX_HEIGHT);
      end else begin
         geo.height = cfg_ff.grid_height;
      end
      if (32'(cfg_ff.layers_in_use) > MAX_LAYERS) begin
         geo.layers = 5'(MAX_LAYERS);
      end else begin
         geo.layers = cfg_ff.layers_in_use;
      end
   end

   pogs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .geo       (geo),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .cmd_empty (cmd_empty)
   );

   pogs_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_LAYERS (MAX_LAYERS),
      .BOX_RADIUS (BOX_RADIUS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .geo       (geo),
      .cmd       (cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_data)
   );

   pogs_fifo #(.WIDTH(RSP_W), .DEPTH(2)) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_data),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_bits),
      .empty (rsp_empty)
   );

   assign rsp_data = rsp_bits;

endmodule
`default_nettype wire

FILE: sv/pogs_fifo.sv
// Small register FIFO used for the command queue and the result queue.
// No dependencies.
`default_nettype none
module pogs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output logic                  empty
);
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNTW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire

FILE: sv/pogs_front.sv
// Front end: accepts items, checks cell index and layer against the grid in use,
// queues classified commands for the back end. Uses pogs_pkg and pogs_fifo.
`default_nettype none
module pogs_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   input  wire pogs_pkg::req_type req_data,
   output logic                   req_full,
   input  wire pogs_pkg::geo_type geo,
   input  wire logic              cmd_pop,
   output pogs_pkg::cmd_type      cmd,
   output logic                   cmd_empty
);
   localparam int CMD_W = $bits(pogs_pkg::cmd_type);

   pogs_pkg::cmd_type cls;
   logic [15:0]       area;
   logic [CMD_W-1:0]  cmd_bits;

   // Classify item
   always_comb begin
      area         = geo.width * geo.height;
      cls.req      = req_data;
      cls.idx_ok   = ({2'b00, req_data.cell_index} < area);
      cls.layer_ok = ({1'b0, req_data.layer_select} < geo.layers);
   end

   pogs_fifo #(.WIDTH(CMD_W), .DEPTH(4)) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (cls),
      .full  (req_full),
      .pop   (cmd_pop),
      .rdata (cmd_bits),
      .empty (cmd_empty)
   );

   assign cmd = cmd_bits;

endmodule
`default_nettype wire

FILE: sv/pogs_back.sv
// Back end: sequencer that runs load, read, refresh and stamp commands against the
// base grid and layer memories. Uses pogs_pkg.
`default_nettype none
module pogs_back #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128,
   parameter int MAX_LAYERS = 16,
   parameter int BOX_RADIUS = 5
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pogs_pkg::cfg_type cfg,
   input  wire pogs_pkg::geo_type geo,
   input  wire pogs_pkg::cmd_type cmd,
   input  wire logic              cmd_empty,
   output logic                   cmd_pop,
   input  wire logic              out_full,
   output logic                   out_push,
   output pogs_pkg::rsp_type      out_data
);
   localparam int XW     = $clog2(MAX_WIDTH);
   localparam int YW     = $clog2(MAX_HEIGHT);
   localparam int CW     = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int LW     = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int GDEPTH = 2 ** CW;
   localparam int LDEPTH = MAX_LAYERS * GDEPTH;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_COPY, S_COPY_END, S_MUL_C, S_MUL_S,
      S_LO, S_HI, S_SUM, S_ABS, S_RND, S_CLIP, S_BOX
   } state_type;

   state_type state_ff;

   // Memories
   logic [7:0] base_mem  [GDEPTH];
   logic [7:0] layer_mem [LDEPTH];
   logic [7:0] base_rd_ff, lay_rd_ff;
   logic              base_we, lay_we;
   logic [CW-1:0]     base_waddr, base_raddr;
   logic [LW+CW-1:0]  lay_waddr, lay_raddr;
   logic [7:0]        lay_wdata;

   // Sequencer registers
   pogs_pkg::cmd_type  cmd_ff;
   logic [LW-1:0]      k_ff;
   logic [CW-1:0]      cp_a_ff;
   logic               cp_valid_ff;
   logic [LW+CW-1:0]   cp_waddr_ff;
   logic signed [32:0] sc_ff, ss_ff;
   logic signed [41:0] accx_ff, accy_ff, mul_ff;
   logic [36:0]        lo_ff;
   logic signed [57:0] v_ff;
   logic [57:0]        mag_ff;
   logic               neg_ff, axis_ff;
   logic signed [28:0] ci_ff, cj_ff;
   logic [XW-1:0]      i_ff, i1_ff;
   logic [YW-1:0]      j_ff, j0_ff, j1_ff;
   logic [10:0]        marked_ff;

   // Datapath signals
   logic signed [24:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [41:0] mul_p;
   logic signed [41:0] cv;
   logic signed [24:0] dpx, dpy;
   logic [27:0]        rnd_mag;
   logic signed [28:0] coord;
   logic signed [30:0] cx, cy, wm1, hm1, xlo, xhi, ylo, yhi, bi0, bi1, bj0, bj1;
   logic               box_empty, last_k, idle_take, ops_none;
   logic [CW-1:0]      box_cell;
   logic [10:0]        marked_inc;

   assign cv      = axis_ff ? accy_ff : accx_ff;
   assign last_k  = (32'(k_ff) + 1 >= 32'(geo.layers));
   assign ops_none = (geo.layers == '0);
   assign idle_take = (state_ff == S_IDLE) && !cmd_empty && !out_full;
   assign cmd_pop = idle_take;
   assign marked_inc = (marked_ff == pogs_pkg::MARK_MAX) ? marked_ff : marked_ff + 1'b1;
   assign dpx = {cmd_ff.req.pos_x[23], cmd_ff.req.pos_x} - {cfg.origin_x[23], cfg.origin_x};
   assign dpy = {cmd_ff.req.pos_y[23], cmd_ff.req.pos_y} - {cfg.origin_y[23], cfg.origin_y};

   // Shared multiplier operand select
   always_comb begin
      mul_a = {{8{cfg.step_distance[16]}}, cfg.step_distance};
      mul_b = {cmd_ff.req.heading_cos[15], cmd_ff.req.heading_cos};
      case (state_ff)
         S_MUL_S: begin
            mul_b = {cmd_ff.req.heading_sin[15], cmd_ff.req.heading_sin};
         end
         S_LO: begin
            mul_a = $signed({4'b0000, cv[20:0]});
            mul_b = $signed({1'b0, cfg.cells_per_meter});
         end
         S_HI: begin
            mul_a = {{4{cv[41]}}, cv[41:21]};
            mul_b = $signed({1'b0, cfg.cells_per_meter});
         end
         default: begin
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // Rounding to nearest, ties away from zero
   always_comb begin
      rnd_mag = 28'((mag_ff + (58'd1 << 29)) >> 30);
      coord   = neg_ff ? -$signed({1'b0, rnd_mag}) : $signed({1'b0, rnd_mag});
   end

   // Box clip against the grid in use
   always_comb begin
      cx  = 31'(ci_ff);
      cy  = 31'(cj_ff);
      wm1 = $signed({23'd0, geo.width}) - 31'sd1;
      hm1 = $signed({23'd0, geo.height}) - 31'sd1;
      xlo = cx - 31'(BOX_RADIUS);
      xhi = cx + 31'(BOX_RADIUS);
      ylo = cy - 31'(BOX_RADIUS);
      yhi = cy + 31'(BOX_RADIUS);
      bi0 = (xlo < 0) ? '0 : xlo;
      bi1 = (xhi > wm1) ? wm1 : xhi;
      bj0 = (ylo < 0) ? '0 : ylo;
      bj1 = (yhi > hm1) ? hm1 : yhi;
      box_empty = (bi0 > bi1) || (bj0 > bj1);
      box_cell  = CW'(i_ff) + CW'(geo.width) * CW'(j_ff);
   end

   // Memory port control
   always_comb begin
      base_we    = idle_take && (cmd.req.op == pogs_pkg::OP_LOAD) && cmd.idx_ok;
      base_waddr = CW'(cmd.req.cell_index);
      base_raddr = cp_a_ff;
      lay_raddr  = {LW'(cmd.req.layer_select), CW'(cmd.req.cell_index)};
      lay_we     = cp_valid_ff || (state_ff == S_BOX);
      lay_waddr  = cp_valid_ff ? cp_waddr_ff : {k_ff, box_cell};
      lay_wdata  = cp_valid_ff ? base_rd_ff : pogs_pkg::OCCUPIED;
   end

   always_ff @(posedge clock) begin
      if (base_we) begin
         base_mem[base_waddr] <= cmd.req.cell_value;
      end
      base_rd_ff <= base_mem[base_raddr];
   end

   always_ff @(posedge clock) begin
      if (lay_we) begin
         layer_mem[lay_waddr] <= lay_wdata;
      end
      lay_rd_ff <= layer_mem[lay_raddr];
   end

   // Result push
   always_comb begin
      out_push = 1'b0;
      out_data = '0;
      case (state_ff)
         S_IDLE: begin
            out_push = idle_take && ((cmd.req.op == pogs_pkg::OP_LOAD) ||
                       (ops_none && ((cmd.req.op == pogs_pkg::OP_STAMP) ||
                                     (cmd.req.op == pogs_pkg::OP_REFRESH))));
         end
         S_READ: begin
            out_push = 1'b1;
            out_data.read_value = (cmd_ff.idx_ok && cmd_ff.layer_ok) ? lay_rd_ff : '0;
         end
         S_COPY_END: begin
            out_push = 1'b1;
         end
         S_CLIP: begin
            out_push = box_empty && last_k;
            out_data.cells_marked = marked_ff;
         end
         S_BOX: begin
            out_push = last_k && (i_ff == i1_ff) && (j_ff == j1_ff);
            out_data.cells_marked = marked_inc;
         end
         default: begin
         end
      endcase
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               cp_valid_ff <= 1'b0;
               if (idle_take) begin
                  cmd_ff    <= cmd;
                  k_ff      <= '0;
                  cp_a_ff   <= '0;
                  marked_ff <= '0;
                  axis_ff   <= 1'b0;
                  case (cmd.req.op)
                     pogs_pkg::OP_READ:    state_ff <= S_READ;
                     pogs_pkg::OP_REFRESH: state_ff <= ops_none ? S_IDLE : S_COPY;
                     pogs_pkg::OP_STAMP:   state_ff <= ops_none ? S_IDLE : S_MUL_C;
                     default:              state_ff <= S_IDLE;
                  endcase
               end
            end
            S_READ: begin
               state_ff <= S_IDLE;
            end
            // Copy base into each layer, one cell a cycle
            S_COPY: begin
               cp_valid_ff <= 1'b1;
               cp_waddr_ff <= {k_ff, cp_a_ff};
               cp_a_ff     <= cp_a_ff + 1'b1;
               if (cp_a_ff == '1) begin
                  if (last_k) begin
                     state_ff <= S_COPY_END;
                  end else begin
                     k_ff <= k_ff + 1'b1;
                  end
               end
            end
            S_COPY_END: begin
               cp_valid_ff <= 1'b0;
               state_ff    <= S_IDLE;
            end
            // Per-layer displacement along heading
            S_MUL_C: begin
               sc_ff    <= mul_p[32:0];
               state_ff <= S_MUL_S;
            end
            S_MUL_S: begin
               ss_ff    <= mul_p[32:0];
               accx_ff  <= {{3{dpx[24]}}, dpx, 14'd0};
               accy_ff  <= {{3{dpy[24]}}, dpy, 14'd0};
               state_ff <= S_LO;
            end
            // Scale to cells in two partial products
            S_LO: begin
               mul_ff   <= mul_p;
               state_ff <= S_HI;
            end
            S_HI: begin
               lo_ff    <= mul_ff[36:0];
               mul_ff   <= mul_p;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               v_ff     <= $signed({mul_ff[36:0], 21'd0}) + $signed({21'd0, lo_ff});
               state_ff <= S_ABS;
            end
            S_ABS: begin
               neg_ff   <= v_ff[57];
               mag_ff   <= v_ff[57] ? 58'(-v_ff) : 58'(v_ff);
               state_ff <= S_RND;
            end
            S_RND: begin
               if (!axis_ff) begin
                  ci_ff    <= coord;
                  axis_ff  <= 1'b1;
                  state_ff <= S_LO;
               end else begin
                  cj_ff    <= coord;
                  axis_ff  <= 1'b0;
                  state_ff <= S_CLIP;
               end
            end
            S_CLIP: begin
               i1_ff <= XW'(bi1);
               j0_ff <= YW'(bj0);
               j1_ff <= YW'(bj1);
               i_ff  <= XW'(bi0);
               j_ff  <= YW'(bj0);
               if (!box_empty) begin
                  state_ff <= S_BOX;
               end else if (last_k) begin
                  state_ff <= S_IDLE;
               end else begin
                  accx_ff  <= accx_ff + 42'(sc_ff);
                  accy_ff  <= accy_ff + 42'(ss_ff);
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_LO;
               end
            end
            // Fill the clipped box one cell a cycle
            S_BOX: begin
               marked_ff <= marked_inc;
               if (j_ff == j1_ff) begin
                  j_ff <= j0_ff;
                  if (i_ff == i1_ff) begin
                     if (last_k) begin
                        state_ff <= S_IDLE;
                     end else begin
                        accx_ff  <= accx_ff + 42'(sc_ff);
                        accy_ff  <= accy_ff + 42'(ss_ff);
                        k_ff     <= k_ff + 1'b1;
                        state_ff <= S_LO;
                     end
                  end else begin
                     i_ff <= i_ff + 1'b1;
                  end
               end else begin
                  j_ff <= j_ff + 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire
